// ----- sv/json_string_unescape_utf8_macros.svh -----
// Assertion macros for the JSON string unescape block.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu assertion failed");

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu assertion failed");

`endif

// ----- sv/jsu_pkg.sv -----
// Types, codes and helper functions shared by the JSON string unescape block.
package jsu_pkg;

   typedef enum logic [1:0] {
      KIND_CONT = 2'd0,
      KIND_NEW  = 2'd1,
      KIND_END  = 2'd2,
      KIND_RSVD = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_BODY    = 3'd1,
      M_ESC     = 3'd2,
      M_HEX     = 3'd3,
      M_NEED_BS = 3'd4,
      M_NEED_U  = 3'd5,
      M_HEX2    = 3'd6
   } mode_type;

   typedef enum logic [3:0] {
      ST_BYTE       = 4'd0,
      ST_DONE       = 4'd1,
      ST_UNTERM     = 4'd2,
      ST_BAD_END    = 4'd3,
      ST_TRUNC_HEX  = 4'd4,
      ST_BAD_HEX    = 4'd5,
      ST_LONE_HIGH  = 4'd6,
      ST_BAD_LOW    = 4'd7,
      ST_STRAY_LOW  = 4'd8,
      ST_BAD_ESC    = 4'd9,
      ST_CTRL_CHAR  = 4'd10
   } status_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
      status_type      status;
   } result_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_U = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST = 16'hDC00;
   localparam logic [15:0] LOW_LAST = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE = 21'h10000;
   localparam logic [20:0] MAX_1B = 21'h7F;
   localparam logic [20:0] MAX_2B = 21'h7FF;
   localparam logic [20:0] MAX_3B = 21'hFFFF;
   localparam logic [7:0] LEAD_2B = 8'hC0;
   localparam logic [7:0] LEAD_3B = 8'hE0;
   localparam logic [7:0] LEAD_4B = 8'hF0;
   localparam logic [7:0] CONT_MARK = 8'h80;

   // Bit 4 set marks a non-hex character.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      return v[4:0];
   endfunction

   function automatic result_type one_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.status = ST_BYTE;
      r.count = 3'd1;
      r.bytes[0] = b;
      return r;
   endfunction

   function automatic result_type error_result(input status_type st);
      result_type r;
      r = '0;
      r.status = st;
      r.count = 3'd1;
      return r;
   endfunction

   function automatic result_type encode(input logic [20:0] cp);
      result_type r;
      r = '0;
      r.status = ST_BYTE;
      if (cp <= MAX_1B) begin
         r.count = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= MAX_2B) begin
         r.count = 3'd2;
         r.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      end else if (cp <= MAX_3B) begin
         r.count = 3'd3;
         r.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      end else begin
         r.count = 3'd4;
         r.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      end
      return r;
   endfunction

endpackage

// ----- sv/json_string_unescape_utf8.sv -----
// Latency: a request's first result is valid the cycle after it is accepted.
// Throughput: one request per cycle while each request yields at most one result
// and rsp_stall stays low; a multi-byte UTF-8 code point stalls the next request
// until its last byte pops, set by the single result port draining the result register.
// Reset (synchronous, active high) returns the decoder to idle and empties the results.
`include "json_string_unescape_utf8_macros.svh"
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_status,
   output logic       rsp_last
);

   result_type res;
   logic       take;
   logic       free;

   assign req_stall = !free;
   assign take = req_valid && free;

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .kind_raw (req_kind),
      .in_byte  (req_in_byte),
      .res      (res)
   );

   jsu_outbuf u_outbuf (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .res          (res),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   `JSU_ASSERT_IMPLY(a_status_is_last, clock, reset, rsp_valid && rsp_status != ST_BYTE, rsp_last && rsp_out_byte == 8'h00)
   `JSU_ASSERT_IMPLY(a_hold_mid_seq, clock, reset, rsp_valid && !rsp_last, req_stall)
   `JSU_ASSERT_NEXT(a_pop_drains, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)

endmodule

// ----- sv/jsu_decode.sv -----
// Decoder state and per-request decode of one string byte into up to four results.
module jsu_decode
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [1:0] kind_raw,
   input  logic [7:0] in_byte,
   output result_type res
);

   mode_type    mode_ff, mode_in, base_mode;
   logic [1:0]  cnt_ff, cnt_in, cnt_b;
   logic [15:0] acc_ff, acc_in, acc_b, acc_new;
   logic [9:0]  high_ff, high_in, high_b;
   logic        bad_ff, bad_in, bad_b, bad_new;
   logic [4:0]  hv;
   logic [3:0]  digit;
   logic [20:0] cp_pair;
   logic        is_new;
   kind_type    kind;

   assign kind = kind_type'(kind_raw);
   assign is_new = (kind == KIND_NEW);
   assign base_mode = is_new ? M_BODY : mode_ff;
   assign cnt_b = is_new ? 2'd0 : cnt_ff;
   assign acc_b = is_new ? 16'd0 : acc_ff;
   assign bad_b = is_new ? 1'b0 : bad_ff;
   assign high_b = is_new ? 10'd0 : high_ff;
   assign hv = hex_value(in_byte);
   assign digit = hv[4] ? 4'd0 : hv[3:0];
   assign bad_new = bad_b | hv[4];
   assign acc_new = {acc_b[11:0], digit};
   assign cp_pair = SUPP_BASE + {1'b0, high_b, acc_new[9:0]};

   always_comb begin
      mode_in = mode_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      high_in = high_ff;
      bad_in = bad_ff;
      res = '0;
      res.status = ST_BYTE;
      unique case (kind)
         KIND_RSVD: begin
         end
         KIND_END: begin
            mode_in = M_IDLE;
            unique case (mode_ff)
               M_BODY:             res = error_result(ST_UNTERM);
               M_ESC:              res = error_result(ST_BAD_END);
               M_HEX, M_HEX2:      res = error_result(ST_TRUNC_HEX);
               M_NEED_BS, M_NEED_U: res = error_result(ST_LONE_HIGH);
               default: begin
               end
            endcase
         end
         default: begin
            mode_in = base_mode;
            cnt_in = cnt_b;
            acc_in = acc_b;
            high_in = high_b;
            bad_in = bad_b;
            unique case (base_mode)
               M_BODY: begin
                  if (in_byte == CH_QUOTE) begin
                     mode_in = M_IDLE;
                     res = error_result(ST_DONE);
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = M_ESC;
                  end else if (in_byte < CTRL_LIMIT) begin
                     mode_in = M_IDLE;
                     res = error_result(ST_CTRL_CHAR);
                  end else begin
                     res = one_byte(in_byte);
                  end
               end
               M_ESC: begin
                  mode_in = M_BODY;
                  unique case (in_byte)
                     CH_QUOTE, CH_BSLASH, CH_SLASH: res = one_byte(in_byte);
                     CH_B: res = one_byte(8'h08);
                     CH_F: res = one_byte(8'h0C);
                     CH_N: res = one_byte(8'h0A);
                     CH_R: res = one_byte(8'h0D);
                     CH_T: res = one_byte(8'h09);
                     CH_U: begin
                        mode_in = M_HEX;
                        cnt_in = 2'd0;
                        acc_in = 16'd0;
                        bad_in = 1'b0;
                     end
                     default: begin
                        mode_in = M_IDLE;
                        res = error_result(ST_BAD_ESC);
                     end
                  endcase
               end
               M_NEED_BS: begin
                  if (in_byte == CH_BSLASH) begin
                     mode_in = M_NEED_U;
                  end else begin
                     mode_in = M_IDLE;
                     res = error_result(ST_LONE_HIGH);
                  end
               end
               M_NEED_U: begin
                  if (in_byte == CH_U) begin
                     mode_in = M_HEX2;
                     cnt_in = 2'd0;
                     acc_in = 16'd0;
                     bad_in = 1'b0;
                  end else begin
                     mode_in = M_IDLE;
                     res = error_result(ST_LONE_HIGH);
                  end
               end
               M_HEX, M_HEX2: begin
                  bad_in = bad_new;
                  acc_in = acc_new;
                  if (cnt_b != 2'd3) begin
                     cnt_in = cnt_b + 2'd1;
                  end else begin
                     cnt_in = 2'd0;
                     if (bad_new) begin
                        mode_in = M_IDLE;
                        res = error_result(ST_BAD_HEX);
                     end else if (base_mode == M_HEX) begin
                        if (acc_new >= HIGH_FIRST && acc_new <= HIGH_LAST) begin
                           high_in = acc_new[9:0];
                           mode_in = M_NEED_BS;
                        end else if (acc_new >= LOW_FIRST && acc_new <= LOW_LAST) begin
                           mode_in = M_IDLE;
                           res = error_result(ST_STRAY_LOW);
                        end else begin
                           mode_in = M_BODY;
                           res = encode({5'd0, acc_new});
                        end
                     end else if (acc_new < LOW_FIRST || acc_new > LOW_LAST) begin
                        mode_in = M_IDLE;
                        res = error_result(ST_BAD_LOW);
                     end else begin
                        mode_in = M_BODY;
                        res = encode(cp_pair);
                     end
                  end
               end
               default: begin
                  mode_in = M_IDLE;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         cnt_ff <= 2'd0;
         acc_ff <= 16'd0;
         high_ff <= 10'd0;
         bad_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
         high_ff <= high_in;
         bad_ff <= bad_in;
      end
   end

endmodule

// ----- sv/jsu_outbuf.sv -----
// Result register that holds up to four decoded results and hands them out one per cycle unless stalled.
module jsu_outbuf
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  result_type res,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_status,
   output logic       rsp_last
);

   logic [2:0]      cnt_ff, cnt_in;
   logic [3:0][7:0] bytes_ff, bytes_in;
   status_type      status_ff, status_in;
   logic            pop;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop = rsp_valid && !rsp_stall;
   assign free = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && !rsp_stall);
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_status = status_ff;
   assign rsp_last = (cnt_ff == 3'd1);

   always_comb begin
      cnt_in = cnt_ff;
      bytes_in = bytes_ff;
      status_in = status_ff;
      priority if (take && res.count != 3'd0) begin
         cnt_in = res.count;
         bytes_in = res.bytes;
         status_in = res.status;
      end else if (pop) begin
         cnt_in = cnt_ff - 3'd1;
         bytes_in = {8'h00, bytes_ff[3:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bytes_ff <= bytes_in;
      status_ff <= status_in;
   end

endmodule

// ----- verif/jsu_tb_pkg.sv -----
// Scoreboard for the JSON string unescape block: its own decoder model and the results still due.
package jsu_tb_pkg;
   import jsu_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      status_type status;
      logic       last;
   } utf8_result_type;

   class unescape_scoreboard;
      mode_type        mode;
      logic [1:0]      digit_count;
      logic [15:0]     hex_accum;
      logic [9:0]      high_half;
      logic            bad_digit;
      utf8_result_type step_results[$];
      utf8_result_type due_results[$];
      int unsigned     errors;

      function new();
         mode = M_IDLE;
         clear_escape();
         high_half = '0;
         errors = 0;
      endfunction

      function void clear_escape();
         digit_count = '0;
         hex_accum = '0;
         bad_digit = 1'b0;
      endfunction

      function void add_result(input logic [7:0] b, input status_type st);
         utf8_result_type r;
         r.out_byte = b;
         r.status = st;
         r.last = 1'b0;
         step_results = {step_results, r};
      endfunction

      function void add_code_point(input logic [20:0] cp);
         if (cp <= 21'h7F) begin
            add_result(cp[7:0], ST_BYTE);
         end else if (cp <= 21'h7FF) begin
            add_result({3'b110, cp[10:6]}, ST_BYTE);
            add_result({2'b10, cp[5:0]}, ST_BYTE);
         end else if (cp <= 21'hFFFF) begin
            add_result({4'b1110, cp[15:12]}, ST_BYTE);
            add_result({2'b10, cp[11:6]}, ST_BYTE);
            add_result({2'b10, cp[5:0]}, ST_BYTE);
         end else begin
            add_result({5'b11110, cp[20:18]}, ST_BYTE);
            add_result({2'b10, cp[17:12]}, ST_BYTE);
            add_result({2'b10, cp[11:6]}, ST_BYTE);
            add_result({2'b10, cp[5:0]}, ST_BYTE);
         end
      endfunction

      function logic [4:0] nibble(input logic [7:0] c);
         logic [7:0] d;
         d = 8'h10;
         if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
         end
         return d[4:0];
      endfunction

      function void decode_body_byte(input logic [7:0] b);
         logic [4:0] d;
         case (mode)
            M_BODY: begin
               if (b == CH_QUOTE) begin
                  mode = M_IDLE;
                  add_result(8'h00, ST_DONE);
               end else if (b == CH_BSLASH) begin
                  mode = M_ESC;
               end else if (b < CTRL_LIMIT) begin
                  mode = M_IDLE;
                  add_result(8'h00, ST_CTRL_CHAR);
               end else begin
                  add_result(b, ST_BYTE);
               end
            end
            M_ESC: begin
               mode = M_BODY;
               case (b)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(b, ST_BYTE);
                  CH_B: add_result(8'h08, ST_BYTE);
                  CH_F: add_result(8'h0C, ST_BYTE);
                  CH_N: add_result(8'h0A, ST_BYTE);
                  CH_R: add_result(8'h0D, ST_BYTE);
                  CH_T: add_result(8'h09, ST_BYTE);
                  CH_U: begin
                     mode = M_HEX;
                     clear_escape();
                  end
                  default: begin
                     mode = M_IDLE;
                     add_result(8'h00, ST_BAD_ESC);
                  end
               endcase
            end
            M_NEED_BS: begin
               if (b == CH_BSLASH) begin
                  mode = M_NEED_U;
               end else begin
                  mode = M_IDLE;
                  add_result(8'h00, ST_LONE_HIGH);
               end
            end
            M_NEED_U: begin
               if (b == CH_U) begin
                  mode = M_HEX2;
                  clear_escape();
               end else begin
                  mode = M_IDLE;
                  add_result(8'h00, ST_LONE_HIGH);
               end
            end
            M_HEX, M_HEX2: begin
               d = nibble(b);
               if (d[4]) begin
                  bad_digit = 1'b1;
                  d = 5'd0;
               end
               hex_accum = {hex_accum[11:0], d[3:0]};
               if (digit_count != 2'd3) begin
                  digit_count = digit_count + 2'd1;
               end else begin
                  digit_count = 2'd0;
                  if (bad_digit) begin
                     mode = M_IDLE;
                     add_result(8'h00, ST_BAD_HEX);
                  end else if (mode == M_HEX) begin
                     if (hex_accum >= HIGH_FIRST && hex_accum <= HIGH_LAST) begin
                        high_half = hex_accum[9:0];
                        mode = M_NEED_BS;
                     end else if (hex_accum >= LOW_FIRST && hex_accum <= LOW_LAST) begin
                        mode = M_IDLE;
                        add_result(8'h00, ST_STRAY_LOW);
                     end else begin
                        mode = M_BODY;
                        add_code_point({5'b00000, hex_accum});
                     end
                  end else if (hex_accum < LOW_FIRST || hex_accum > LOW_LAST) begin
                     mode = M_IDLE;
                     add_result(8'h00, ST_BAD_LOW);
                  end else begin
                     mode = M_BODY;
                     add_code_point(SUPP_BASE + {1'b0, high_half, hex_accum[9:0]});
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void note_request(input logic [1:0] kind, input logic [7:0] b);
         step_results.delete();
         if (kind == KIND_END) begin
            case (mode)
               M_BODY: add_result(8'h00, ST_UNTERM);
               M_ESC: add_result(8'h00, ST_BAD_END);
               M_HEX, M_HEX2: add_result(8'h00, ST_TRUNC_HEX);
               M_NEED_BS, M_NEED_U: add_result(8'h00, ST_LONE_HIGH);
               default: ;
            endcase
            mode = M_IDLE;
         end else if (kind != KIND_RSVD) begin
            if (kind == KIND_NEW) begin
               mode = M_BODY;
               clear_escape();
               high_half = '0;
            end
            if (mode != M_IDLE) begin
               decode_body_byte(b);
            end
         end
         if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
         end
         due_results = {due_results, step_results};
      endfunction

      function void check_response(input logic [7:0] out_byte, input logic [3:0] status,
                                   input logic last);
         utf8_result_type e;
         if (due_results.size() == 0) begin
            $error("unexpected result: out_byte %02h status %0d last %0b",
                   out_byte, status, last);
            errors++;
            return;
         end
         e = due_results.pop_front();
         if (out_byte !== e.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h", e.out_byte, out_byte);
            errors++;
         end
         if (status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (last !== e.last) begin
            $error("last mismatch: expected %0b, actual %0b", e.last, last);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return due_results.size();
      endfunction
   endclass

endpackage

// ----- verif/json_string_unescape_utf8_tb.sv -----
// JSON string unescape testbench top: directed then random JSON string bodies against the scoreboard.
module json_string_unescape_utf8_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;
   import jsu_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 330;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_kind;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_status;
   logic       rsp_last;

   unescape_scoreboard sb = new();
   bit steady = 1'b0;
   bit opening = 1'b0;
   int sent_count = 0;
   int idle_cycles = 0;

   json_string_unescape_utf8 u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 37);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_out_byte, rsp_status, rsp_last);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_kind, req_in_byte);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [7:0] b);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] b);
      send_request(opening ? KIND_NEW : KIND_CONT, b);
      opening = 1'b0;
      sent_count++;
   endtask

   task automatic send_end();
      send_request(KIND_END, 8'($urandom));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return {4'b0000, n} + 8'h30;
      end else if ($urandom_range(1) == 1) begin
         return {4'b0000, n} + 8'h37;
      end
      return {4'b0000, n} + 8'h57;
   endfunction

   task automatic send_hex_digits(input logic [15:0] v, input int digits, input int bad_pos);
      logic [7:0] c;
      for (int i = 0; i < digits; i++) begin
         if (i == bad_pos) begin
            do begin
               c = 8'($urandom);
            end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66));
         end else begin
            c = hex_char(v[15 - 4 * i -: 4]);
         end
         send_text(c);
      end
   endtask

   task automatic send_unit(input logic [15:0] v, input int bad_pos);
      send_text(CH_BSLASH);
      send_text(CH_U);
      send_hex_digits(v, 4, bad_pos);
   endtask

   function automatic logic [15:0] pick_bmp();
      logic [15:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(7))
               0: v = 16'h0000;
               1: v = 16'h007F;
               2: v = 16'h0080;
               3: v = 16'h07FF;
               4: v = 16'h0800;
               5: v = 16'hD7FF;
               6: v = 16'hE000;
               default: v = 16'hFFFF;
            endcase
         end
         1, 2, 3: v = 16'($urandom_range(16'h7F, 0));
         4, 5, 6: v = 16'($urandom_range(16'h7FF, 16'h80));
         default: begin
            do begin
               v = 16'($urandom_range(16'hFFFF, 16'h800));
            end while (v >= HIGH_FIRST && v <= LOW_LAST);
         end
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_half(input logic [15:0] first);
      case ($urandom_range(9))
         0: return first;
         1: return first + 16'h03FF;
         default: return first + 16'($urandom_range(16'h3FF, 0));
      endcase
   endfunction

   task automatic send_valid_token();
      logic [7:0] c;
      case ($urandom_range(99)) inside
         [0:39]: begin
            do begin
               c = 8'($urandom_range(255, 32));
            end while (c == CH_QUOTE || c == CH_BSLASH);
            send_text(c);
         end
         [40:54]: begin
            case ($urandom_range(7))
               0: c = CH_QUOTE;
               1: c = CH_BSLASH;
               2: c = CH_SLASH;
               3: c = CH_B;
               4: c = CH_F;
               5: c = CH_N;
               6: c = CH_R;
               default: c = CH_T;
            endcase
            send_text(CH_BSLASH);
            send_text(c);
         end
         [55:79]: send_unit(pick_bmp(), -1);
         default: begin
            send_unit(pick_half(HIGH_FIRST), -1);
            send_unit(pick_half(LOW_FIRST), -1);
         end
      endcase
   endtask

   task automatic send_string_end();
      logic [7:0]  c;
      logic [15:0] v;
      int          k;
      case ($urandom_range(99)) inside
         [0:54]: send_text(CH_QUOTE);
         [55:61]: send_end();
         default: begin
            case ($urandom_range(13))
               0: send_text(8'($urandom_range(31, 0)));
               1: begin
                  do begin
                     c = 8'($urandom);
                  end while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH ||
                             c == CH_B || c == CH_F || c == CH_N || c == CH_R ||
                             c == CH_T || c == CH_U);
                  send_text(CH_BSLASH);
                  send_text(c);
               end
               2: send_unit(pick_bmp(), $urandom_range(3));
               3, 12: begin
                  if ($urandom_range(3) == 0) begin
                     send_unit(pick_half(HIGH_FIRST), -1);
                  end
                  k = $urandom_range(3);
                  send_text(CH_BSLASH);
                  send_text(CH_U);
                  send_hex_digits(pick_bmp(), k,
                                  (k > 0 && $urandom_range(1) == 1) ? $urandom_range(k - 1) : -1);
                  send_end();
               end
               4: begin
                  send_text(CH_BSLASH);
                  send_end();
               end
               5: send_unit(pick_half(LOW_FIRST), -1);
               6: begin
                  case ($urandom_range(3))
                     0: v = 16'hDBFF;
                     1: v = 16'hE000;
                     default: begin
                        do begin
                           v = 16'($urandom);
                        end while (v >= LOW_FIRST && v <= LOW_LAST);
                     end
                  endcase
                  send_unit(pick_half(HIGH_FIRST), -1);
                  send_unit(v, -1);
               end
               7: begin
                  send_unit(pick_half(HIGH_FIRST), -1);
                  do begin
                     c = 8'($urandom);
                  end while (c == CH_BSLASH);
                  send_text(c);
               end
               8: begin
                  send_unit(pick_half(HIGH_FIRST), -1);
                  send_text(CH_BSLASH);
                  do begin
                     c = 8'($urandom);
                  end while (c == CH_U);
                  send_text(c);
               end
               9: begin
                  send_unit(pick_half(HIGH_FIRST), -1);
                  send_end();
               end
               10: begin
                  send_unit(pick_half(HIGH_FIRST), -1);
                  send_text(CH_BSLASH);
                  send_end();
               end
               11: begin
                  send_unit(pick_half(HIGH_FIRST), -1);
                  send_unit(pick_half(LOW_FIRST), $urandom_range(3));
               end
               default: begin
                  // leave the string open mid escape; the next string restarts it
                  send_text(CH_BSLASH);
                  if ($urandom_range(1) == 1) begin
                     send_text(CH_U);
                     send_hex_digits(pick_bmp(), $urandom_range(3), -1);
                  end
               end
            endcase
         end
      endcase
   endtask

   task automatic send_string();
      int tokens;
      if ($urandom_range(9) == 0) begin
         send_request(2'($urandom_range(3)) == KIND_NEW ? KIND_RSVD : 2'($urandom_range(3)),
                      8'($urandom));
      end
      opening = 1'b1;
      tokens = $urandom_range(8);
      for (int i = 0; i < tokens; i++) begin
         send_valid_token();
         if (!opening && $urandom_range(19) == 0) begin
            send_request(KIND_RSVD, 8'($urandom));
         end
      end
      send_string_end();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_CONT;
      req_in_byte = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(KIND_CONT, 8'h41);
      send_request(KIND_END, 8'h00);
      send_request(KIND_RSVD, 8'hFF);
      send_request(KIND_NEW, 8'h20);
      send_request(KIND_CONT, 8'hFF);
      send_request(KIND_CONT, 8'h1F);
      send_request(KIND_NEW, CH_BSLASH);
      send_request(KIND_CONT, CH_N);
      send_request(KIND_CONT, CH_BSLASH);
      send_request(KIND_CONT, CH_U);
      send_request(KIND_CONT, 8'h44);
      send_request(KIND_CONT, 8'h38);
      send_request(KIND_CONT, 8'h33);
      send_request(KIND_CONT, 8'h44);
      send_request(KIND_CONT, CH_BSLASH);
      send_request(KIND_CONT, CH_U);
      send_request(KIND_CONT, 8'h64);
      send_request(KIND_CONT, 8'h65);
      send_request(KIND_CONT, 8'h30);
      send_request(KIND_CONT, 8'h30);
      send_request(KIND_CONT, CH_QUOTE);
      send_request(KIND_NEW, CH_BSLASH);
      send_request(KIND_END, 8'hA5);
      wait_drained();

      while (sent_count < RANDOM_ITEMS) begin
         steady = (sent_count >= 120 && sent_count < 200);
         send_string();
         if ($urandom_range(19) == 0) begin
            wait_drained();
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (16) @(negedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- json_string_unescape_utf8.f -----
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_outbuf.sv
sv/json_string_unescape_utf8.sv
verif/jsu_tb_pkg.sv
verif/json_string_unescape_utf8_tb.sv
